// ===== rtl/spss_pkg.sv =====
// Package for the supply protection sequencer.
// Holds payload, state and configuration types plus the debounce and ramp constants.
// No dependencies.
package spss_pkg;

	localparam logic [9:0]  DC_TICKS     = 10'd1000;
	localparam logic [6:0]  OTP_TICKS    = 7'd100;
	localparam logic [3:0]  HICCUP_TICKS = 4'd10;
	localparam logic [9:0]  INRUSH_TICKS = 10'd1000;
	localparam logic [7:0]  FAN_RUNON    = 8'd60;
	localparam logic [7:0]  FAN_CNT_MAX  = 8'd255;
	localparam logic [12:0] SP_CEIL      = 13'd4595;
	localparam logic [16:0] SP_CEIL_FX   = {SP_CEIL, 4'b0000};

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;
	localparam logic [11:0] CURRENT_STEP_RST = 12'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE_SEL      = 2'd0,
		REG_CURRENT_LIMIT = 2'd1,
		REG_VOLTAGE_LIMIT = 2'd2,
		REG_CURRENT_STEP  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic        mode_sel;
		logic [11:0] current_limit;
		logic [11:0] voltage_limit;
		logic [11:0] current_step;
	} cfg_t;

	typedef struct packed {
		logic dc_fault_pin;
		logic otp_pin;
		logic hiccup_pin;
		logic link_lost;
		logic tacho_fault;
		logic run_request;
		logic fan_tick;
	} item_t;

	typedef struct packed {
		logic        ac_relay_on;
		logic        fan_on;
		logic        pfc_on;
		logic        inrush_relay_on;
		logic        sputter_on;
		logic        run_led;
		logic        abnormal_led;
		logic        fan_flag;
		logic [2:0]  fault_flags;
		logic [12:0] current_dac;
		logic [12:0] voltage_dac;
	} result_t;

	typedef struct packed {
		logic ac;
		logic fan;
		logic pfc;
		logic inr;
		logic spt;
		logic run;
		logic abn;
		logic ffl;
	} drive_t;

	typedef struct packed {
		logic [9:0]  dc_count;
		logic [6:0]  otp_count;
		logic [3:0]  hiccup_count;
		logic [9:0]  inrush_count;
		logic [7:0]  fan_runon_cnt;
		logic        fan_running;
		logic        st_dc;
		logic        st_otp;
		logic        st_hic;
		logic        st_inr;
		logic [16:0] cur_sp;
		logic [12:0] volt_sp;
		drive_t      drv;
	} state_t;

endpackage

// ===== rtl/spss_step.sv =====
// One control tick of the sequencer: next state and result from current state and item.
// Purely combinational; uses spss_pkg types and constants.
module spss_step import spss_pkg::*; (
	input  state_t  st,
	input  cfg_t    cfg,
	input  item_t   din,
	output state_t  nxt,
	output result_t dout
);

	function automatic state_t stage_off(input state_t s);
		state_t r;
		r         = s;
		r.drv.pfc = 1'b0;
		r.cur_sp  = '0;
		r.volt_sp = '0;
		r.drv.inr = 1'b0;
		r.drv.spt = 1'b0;
		r.drv.abn = 1'b1;
		r.drv.run = 1'b0;
		r.st_inr  = 1'b0;
		return r;
	endfunction

	function automatic state_t ramp(input state_t s, input cfg_t c);
		state_t      r;
		logic [16:0] lim;
		logic [16:0] step;
		logic [12:0] vlim;
		r    = s;
		lim  = {1'b0, c.current_limit, 4'b0000};
		step = {5'b0, c.current_step};
		vlim = {1'b0, c.voltage_limit};
		if (r.cur_sp < lim && r.cur_sp < SP_CEIL_FX) begin
			r.cur_sp = r.cur_sp + step;
		end
		if (r.cur_sp >= lim && r.cur_sp != '0) begin
			r.cur_sp = (r.cur_sp > step) ? r.cur_sp - step : '0;
		end
		if (r.volt_sp < vlim && r.volt_sp < SP_CEIL) begin
			r.volt_sp = r.volt_sp + 13'd1;
		end
		if (r.volt_sp >= vlim && r.volt_sp != '0) begin
			r.volt_sp = r.volt_sp - 13'd1;
		end
		return r;
	endfunction

	state_t s;
	logic   go;

	always_comb begin
		s  = st;
		go = !din.link_lost && din.run_request;

		if (s.fan_running && din.fan_tick && s.fan_runon_cnt != FAN_CNT_MAX) begin
			s.fan_runon_cnt = s.fan_runon_cnt + 8'd1;
		end

		// DC-OK: low means good at once, high debounces towards a fault
		if (din.dc_fault_pin) begin
			s.dc_count = s.dc_count + 10'd1;
			if (s.dc_count >= DC_TICKS) begin
				s.st_dc    = 1'b0;
				s.dc_count = DC_TICKS;
			end
		end else begin
			s.st_dc    = 1'b1;
			s.dc_count = '0;
		end

		if (!din.otp_pin) begin
			s.st_otp    = 1'b0;
			s.otp_count = '0;
		end else begin
			s.otp_count = s.otp_count + 7'd1;
			if (s.otp_count >= OTP_TICKS) begin
				s.st_otp    = 1'b1;
				s.otp_count = OTP_TICKS;
			end
		end

		// hiccup counts while the pin is low; a declared hiccup holds until the pin rises
		if (!din.hiccup_pin) begin
			if (cfg.mode_sel) begin
				s.hiccup_count = '0;
			end else begin
				s.hiccup_count = s.hiccup_count + 4'd1;
				if (s.hiccup_count >= HICCUP_TICKS) begin
					s.st_hic       = 1'b1;
					s.hiccup_count = HICCUP_TICKS;
					s.cur_sp       = '0;
					s.volt_sp      = '0;
				end
			end
		end else begin
			s.st_hic       = 1'b0;
			s.hiccup_count = '0;
		end

		if (go && !s.st_hic && !s.st_otp) begin
			s.drv.ac  = 1'b1;
			s.drv.fan = 1'b1;
			if (!din.tacho_fault) begin
				s.drv.pfc       = 1'b1;
				s.fan_running   = 1'b0;
				s.fan_runon_cnt = '0;
				if (s.st_dc) begin
					if (s.inrush_count < INRUSH_TICKS) begin
						s.inrush_count = s.inrush_count + 10'd1;
					end else begin
						s.inrush_count = INRUSH_TICKS;
						s.drv.inr      = 1'b1;
						s.st_inr       = 1'b1;
					end
					if (s.st_inr) begin
						s.drv.spt = 1'b1;
						s.drv.ffl = 1'b1;
						s.drv.run = 1'b1;
						s.drv.abn = 1'b0;
						s         = ramp(s, cfg);
					end
				end else begin
					s = stage_off(s);
				end
			end else begin
				s = stage_off(s);
			end
		end else if (go && s.st_hic && !s.st_otp) begin
			s.cur_sp  = '0;
			s.volt_sp = '0;
			s.drv.spt = 1'b0;
			s.drv.run = 1'b0;
		end else begin
			// shut down, keep the fan running on until the timer expires
			s.drv.spt      = 1'b0;
			s.drv.inr      = 1'b0;
			s.drv.pfc      = 1'b0;
			s.cur_sp       = '0;
			s.volt_sp      = '0;
			s.drv.run      = 1'b0;
			s.drv.abn      = 1'b0;
			s.drv.ac       = 1'b0;
			s.fan_running  = 1'b1;
			s.inrush_count = '0;
			s.st_inr       = 1'b0;
			if (s.fan_runon_cnt > FAN_RUNON) begin
				s.drv.fan       = 1'b0;
				s.fan_running   = 1'b0;
				s.fan_runon_cnt = '0;
			end
		end

		if (s.st_hic) begin
			s.drv.spt = 1'b0;
			s.drv.abn = 1'b1;
		end

		nxt                  = s;
		dout.ac_relay_on     = s.drv.ac;
		dout.fan_on          = s.drv.fan;
		dout.pfc_on          = s.drv.pfc;
		dout.inrush_relay_on = s.drv.inr;
		dout.sputter_on      = s.drv.spt;
		dout.run_led         = s.drv.run;
		dout.abnormal_led    = s.drv.abn;
		dout.fan_flag        = s.drv.ffl;
		dout.fault_flags     = {s.st_hic, s.st_otp, s.st_dc};
		dout.current_dac     = s.cur_sp[16:4];
		dout.voltage_dac     = s.volt_sp;
	end

endmodule

// ===== rtl/supply_protection_sequencer_unit.sv =====
// Top level of the supply protection sequencer: input register, tick logic, result register.
// Depends on spss_pkg and spss_step.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   item (item_t)
//   result    out        result_valid / result_stall  result (result_t)
//   cfg       in         cfg_we                    cfg_idx, cfg_wdata
//
// One tick per cycle while the result is not stalled; an item is taken into the input
// register, and its result follows from the state update into the result register.
// Reset clears all sequencer state and the drive levels and returns the configuration
// to its reset values.
// A stalled result holds the tick stage; the input register then stalls upstream.
module supply_protection_sequencer_unit import spss_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t result_nxt;
	result_t result_q;
	logic    result_valid_q;
	logic    out_free;
	logic    advance;

	assign out_free     = !result_valid_q || !result_stall;
	assign advance      = valid_s1 && out_free;
	assign item_stall   = valid_s1 && !out_free;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_sel      <= 1'b0;
			cfg_q.current_limit <= '0;
			cfg_q.voltage_limit <= '0;
			cfg_q.current_step  <= CURRENT_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_MODE_SEL:      cfg_q.mode_sel      <= cfg_wdata[0];
				REG_CURRENT_LIMIT: cfg_q.current_limit <= cfg_wdata;
				REG_VOLTAGE_LIMIT: cfg_q.voltage_limit <= cfg_wdata;
				REG_CURRENT_STEP:  cfg_q.current_step  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	spss_step u_step (
		.st   (state_q),
		.cfg  (cfg_q),
		.din  (item_s1),
		.nxt  (state_nxt),
		.dout (result_nxt)
	);

	// advance state only when the tick result has somewhere to go
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for supply_protection_sequencer_unit: random ticks, gaps and stalls,
// with a cycle-free model of the debounce, sequencing and ramp logic scoring every transfer.
// Depends on spss_pkg and the RTL of the unit.
module testbench;
	import spss_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [9:0]  DC_DEBOUNCE     = 10'd1000;
	localparam logic [6:0]  OTP_DEBOUNCE    = 7'd100;
	localparam logic [3:0]  HICCUP_DEBOUNCE = 4'd10;
	localparam logic [9:0]  INRUSH_COUNT    = 10'd1000;
	localparam logic [7:0]  FAN_RUN_ON      = 8'd60;
	localparam logic [7:0]  FAN_CNT_TOP     = 8'd255;
	localparam logic [16:0] CURRENT_CEIL_FX = 17'd73520;
	localparam logic [12:0] VOLTAGE_CEIL    = 13'd4595;
	localparam int          STALL_LIMIT     = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	supply_protection_sequencer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata)
	);

	// register copies
	logic        mode_q = 1'b0;
	logic [11:0] i_limit = '0;
	logic [11:0] v_limit = '0;
	logic [11:0] i_step = 12'd16;

	// sequencer state
	logic [9:0]  dc_cnt = '0;
	logic [6:0]  otp_cnt = '0;
	logic [3:0]  hic_cnt = '0;
	logic [9:0]  inr_cnt = '0;
	logic [7:0]  fan_tmr = '0;
	logic        fan_run = 1'b0;
	logic        dc_good = 1'b0;
	logic        otp_flt = 1'b0;
	logic        hic_flt = 1'b0;
	logic        inr_done = 1'b0;
	logic [16:0] cur_sp = '0;
	logic [12:0] volt_sp = '0;
	logic        ac_lv = 1'b0, fan_lv = 1'b0, pfc_lv = 1'b0, inr_lv = 1'b0;
	logic        spt_lv = 1'b0, run_lv = 1'b0, abn_lv = 1'b0, ffl_lv = 1'b0;

	item_t   pending_ticks[$];
	result_t predicted_outputs[$];
	result_t next_out;
	result_t want_out;

	int  n_ticks = 0;
	int  n_outputs = 0;
	int  n_errors = 0;
	int  n_writes = 0;
	int  n_sputter = 0;
	int  n_hiccup = 0;
	int  n_overtemp = 0;
	int  n_dc_fault = 0;
	int  idle_cycles = 0;
	int  issued = 0;
	logic steady;

	assign steady = (n_ticks >= 200) && (n_ticks < 500);

	function automatic bit chance(int unsigned per_mille);
		return $urandom_range(999) < per_mille;
	endfunction

	function automatic item_t make_tick(logic dc, logic otp, logic hic, logic com, logic tacho,
			logic run, logic ftick);
		item_t t;
		t.dc_fault_pin = dc;
		t.otp_pin = otp;
		t.hiccup_pin = hic;
		t.link_lost = com;
		t.tacho_fault = tacho;
		t.run_request = run;
		t.fan_tick = ftick;
		return t;
	endfunction

	task automatic power_stage_off();
		pfc_lv = 1'b0;
		cur_sp = '0;
		volt_sp = '0;
		inr_lv = 1'b0;
		spt_lv = 1'b0;
		abn_lv = 1'b1;
		run_lv = 1'b0;
		inr_done = 1'b0;
	endtask

	task automatic advance_sequencer(input item_t t, output result_t r);
		logic [15:0] i_lim_fx;
		i_lim_fx = {i_limit, 4'b0000};
		if (fan_run && t.fan_tick && fan_tmr != FAN_CNT_TOP)
			fan_tmr++;

		if (t.dc_fault_pin) begin
			dc_cnt++;
			if (dc_cnt >= DC_DEBOUNCE) begin
				dc_good = 1'b0;
				dc_cnt = DC_DEBOUNCE;
			end
		end else begin
			dc_good = 1'b1;
			dc_cnt = '0;
		end

		if (!t.otp_pin) begin
			otp_flt = 1'b0;
			otp_cnt = '0;
		end else begin
			otp_cnt++;
			if (otp_cnt >= OTP_DEBOUNCE) begin
				otp_flt = 1'b1;
				otp_cnt = OTP_DEBOUNCE;
			end
		end

		// nonzero mode holds the counter clear but keeps an earlier hiccup
		if (t.hiccup_pin) begin
			hic_flt = 1'b0;
			hic_cnt = '0;
		end else if (mode_q) begin
			hic_cnt = '0;
		end else begin
			hic_cnt++;
			if (hic_cnt >= HICCUP_DEBOUNCE) begin
				hic_flt = 1'b1;
				hic_cnt = HICCUP_DEBOUNCE;
				cur_sp = '0;
				volt_sp = '0;
			end
		end

		if (!t.link_lost && t.run_request && !hic_flt && !otp_flt) begin
			ac_lv = 1'b1;
			fan_lv = 1'b1;
			if (!t.tacho_fault) begin
				pfc_lv = 1'b1;
				fan_run = 1'b0;
				fan_tmr = '0;
				if (dc_good) begin
					if (inr_cnt < INRUSH_COUNT) begin
						inr_cnt++;
					end else begin
						inr_lv = 1'b1;
						inr_done = 1'b1;
					end
					if (inr_done) begin
						spt_lv = 1'b1;
						ffl_lv = 1'b1;
						run_lv = 1'b1;
						abn_lv = 1'b0;
						// step up first, then back off once at or over the target
						if (cur_sp < i_lim_fx && cur_sp < CURRENT_CEIL_FX)
							cur_sp = cur_sp + i_step;
						if (cur_sp >= i_lim_fx && cur_sp != '0)
							cur_sp = (cur_sp > i_step) ? cur_sp - i_step : '0;
						if (volt_sp < v_limit && volt_sp < VOLTAGE_CEIL)
							volt_sp++;
						if (volt_sp >= v_limit && volt_sp != '0)
							volt_sp--;
					end
				end else begin
					power_stage_off();
				end
			end else begin
				power_stage_off();
			end
		end else if (!t.link_lost && t.run_request && !otp_flt) begin
			cur_sp = '0;
			volt_sp = '0;
			spt_lv = 1'b0;
			run_lv = 1'b0;
		end else begin
			spt_lv = 1'b0;
			inr_lv = 1'b0;
			pfc_lv = 1'b0;
			cur_sp = '0;
			volt_sp = '0;
			run_lv = 1'b0;
			abn_lv = 1'b0;
			ac_lv = 1'b0;
			fan_run = 1'b1;
			inr_cnt = '0;
			inr_done = 1'b0;
			if (fan_tmr > FAN_RUN_ON) begin
				fan_lv = 1'b0;
				fan_run = 1'b0;
				fan_tmr = '0;
			end
		end

		if (hic_flt) begin
			spt_lv = 1'b0;
			abn_lv = 1'b1;
		end

		r.ac_relay_on = ac_lv;
		r.fan_on = fan_lv;
		r.pfc_on = pfc_lv;
		r.inrush_relay_on = inr_lv;
		r.sputter_on = spt_lv;
		r.run_led = run_lv;
		r.abnormal_led = abn_lv;
		r.fan_flag = ffl_lv;
		r.fault_flags = {hic_flt, otp_flt, dc_good};
		r.current_dac = cur_sp[16:4];
		r.voltage_dac = volt_sp;
	endtask

	function automatic void check_field(string name, logic [12:0] want, logic [12:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// powered run with pins that settle now and then, short fault bursts on top
	task automatic queue_powered(int n, int dc_from, int dc_to, int otp_from, int otp_to);
		int  otp_left = 0;
		int  hic_left = 0;
		logic hot;
		for (int k = 0; k < n; k++) begin
			if (otp_left == 0 && chance(15))
				otp_left = $urandom_range(40, 1);
			if (hic_left == 0 && chance(20))
				hic_left = $urandom_range(14, 1);
			hot = (otp_left != 0) || (k >= otp_from && k < otp_to);
			pending_ticks.push_back(make_tick(k >= dc_from && k < dc_to, hot, hic_left == 0,
				1'b0, chance(15), 1'b1, chance(500)));
			if (otp_left != 0)
				otp_left--;
			if (hic_left != 0)
				hic_left--;
		end
	endtask

	task automatic queue_shutdown(int n);
		for (int k = 0; k < n; k++)
			pending_ticks.push_back(make_tick(chance(100), chance(50), !chance(50), chance(300),
				chance(200), chance(100), chance(800)));
	endtask

	// pins that toggle at their own rates, so holds of varied length turn up
	task automatic queue_wander(int n);
		int unsigned flip_pm [7] = '{500, 40, 50, 30, 100, 10, 30};
		logic [6:0] lv;
		lv = 7'($urandom);
		for (int k = 0; k < n; k++) begin
			for (int b = 0; b < 7; b++)
				if (chance(flip_pm[b]))
					lv[b] = ~lv[b];
			pending_ticks.push_back(item_t'(lv));
		end
	endtask

	task automatic queue_hold(int n, item_t t);
		repeat (n)
			pending_ticks.push_back(t);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [11:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_MODE_SEL:      mode_q = val[0];
			REG_CURRENT_LIMIT: i_limit = val;
			REG_VOLTAGE_LIMIT: v_limit = val;
			REG_CURRENT_STEP:  i_step = val;
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		while (pending_ticks.size() != 0 || predicted_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// score the tick on the bus and move on
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			advance_sequencer(item, next_out);
			predicted_outputs.push_back(next_out);
			void'(pending_ticks.pop_front());
			n_ticks++;
		end
	end

	// hold until transferred, then present the next tick or a gap
	always @(negedge clk) begin
		if (arst_n !== 1'b1) begin
			item_valid <= 1'b0;
			item <= '0;
		end else if (!item_valid || n_ticks == issued) begin
			if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
				item_valid <= 1'b1;
				item <= pending_ticks[0];
				issued = n_ticks + 1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		result_stall <= !steady && ($urandom_range(99) < 27);

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			n_outputs++;
			if (predicted_outputs.size() == 0) begin
				n_errors++;
				$display("%0t ns: output with nothing expected, expected none, got %h", $time,
					result);
			end else begin
				want_out = predicted_outputs.pop_front();
				check_field("ac_relay_on", 13'(want_out.ac_relay_on),
					13'(result.ac_relay_on));
				check_field("fan_on", 13'(want_out.fan_on), 13'(result.fan_on));
				check_field("pfc_on", 13'(want_out.pfc_on), 13'(result.pfc_on));
				check_field("inrush_relay_on", 13'(want_out.inrush_relay_on),
					13'(result.inrush_relay_on));
				check_field("sputter_on", 13'(want_out.sputter_on),
					13'(result.sputter_on));
				check_field("run_led", 13'(want_out.run_led), 13'(result.run_led));
				check_field("abnormal_led", 13'(want_out.abnormal_led),
					13'(result.abnormal_led));
				check_field("fan_flag", 13'(want_out.fan_flag), 13'(result.fan_flag));
				check_field("fault_flags", 13'(want_out.fault_flags),
					13'(result.fault_flags));
				check_field("current_dac", want_out.current_dac, result.current_dac);
				check_field("voltage_dac", want_out.voltage_dac, result.voltage_dac);
			end
			n_sputter += int'(result.sputter_on);
			n_hiccup += int'(result.fault_flags[2]);
			n_overtemp += int'(result.fault_flags[1]);
			n_dc_fault += int'(!result.fault_flags[0]);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles == STALL_LIMIT) begin
					$display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
					$display("[FAIL] regression broken");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_MODE_SEL;
		cfg_wdata = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: each pin alone, all pins, tacho and com drop-outs, hiccup declared
		pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 0, 0));
		pending_ticks.push_back(item_t'('1));
		for (int b = 0; b < 7; b++)
			pending_ticks.push_back(item_t'(7'd1 << b));
		pending_ticks.push_back(make_tick(0, 0, 1, 0, 0, 1, 0));
		pending_ticks.push_back(make_tick(0, 0, 1, 0, 1, 1, 1));
		pending_ticks.push_back(make_tick(0, 0, 1, 1, 0, 1, 0));
		queue_hold(11, make_tick(0, 0, 0, 0, 0, 1, 0));
		pending_ticks.push_back(make_tick(0, 0, 1, 0, 0, 1, 1));
		settle();

		// full inrush, ramp, then a DC fault while running and recovery on DC good
		write_reg(REG_MODE_SEL, 12'd0);
		write_reg(REG_CURRENT_LIMIT, 12'd4095);
		write_reg(REG_VOLTAGE_LIMIT, 12'd25);
		write_reg(REG_CURRENT_STEP, 12'd4095);
		queue_powered(1180, 100, 1115, 0, 0);
		settle();

		// retarget while running, finish with a declared hiccup
		write_reg(REG_CURRENT_LIMIT, 12'd3000);
		write_reg(REG_VOLTAGE_LIMIT, 12'd4095);
		write_reg(REG_CURRENT_STEP, 12'd1);
		queue_powered(30, 0, 0, 0, 0);
		queue_hold(12, make_tick(0, 0, 0, 0, 0, 1, 0));
		settle();

		// hiccup suppressed: the earlier one must stay until the pin goes high
		write_reg(REG_MODE_SEL, 12'd1);
		write_reg(REG_CURRENT_LIMIT, 12'd0);
		write_reg(REG_VOLTAGE_LIMIT, 12'd0);
		write_reg(REG_CURRENT_STEP, 12'd0);
		queue_hold(5, make_tick(0, 0, 0, 0, 0, 1, 0));
		queue_powered(30, 0, 0, 0, 0);
		queue_shutdown(80);
		settle();

		write_reg(REG_MODE_SEL, 12'd0);
		write_reg(REG_CURRENT_LIMIT, 12'($urandom_range(4095)));
		write_reg(REG_VOLTAGE_LIMIT, 12'($urandom_range(63)));
		write_reg(REG_CURRENT_STEP, 12'($urandom_range(4095)));
		queue_wander(30);
		settle();

		// sustained over-temperature in a powered run
		write_reg(REG_CURRENT_LIMIT, 12'($urandom_range(4095)));
		write_reg(REG_VOLTAGE_LIMIT, 12'($urandom_range(4095)));
		write_reg(REG_CURRENT_STEP, 12'($urandom_range(4095)));
		queue_powered(140, 0, 0, 10, 120);
		queue_wander(20);
		settle();

		$display("covered %0d control ticks and %0d outputs across %0d register writes",
			n_ticks, n_outputs, n_writes);
		$display("outputs with sputter on %0d, hiccup %0d, over-temperature %0d, DC fault %0d",
			n_sputter, n_hiccup, n_overtemp, n_dc_fault);
		if (n_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
